/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the point run filter.
// No dependencies; define SYNTH to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
		else $error("assertion failed");
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/prgs_pkg.sv */
// Package of the point run gap segment filter: widths, defaults, register codes.
// No dependencies.
package prgs_pkg;

	localparam int RUN_DEPTH_DEF  = 63;
	localparam int COORD_BITS_DEF = 20;

	localparam int GAP_W      = 16;
	localparam int MINP_W     = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int SQ_W       = 2 * GAP_W;
	localparam int ACC_W      = SQ_W + 2;

	localparam logic [GAP_W-1:0]  GAP_RESET  = 16'd200;
	localparam logic [MINP_W-1:0] MINP_RESET = 6'd1;

	localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_POINTS = 1'b1;

	typedef struct packed {
		logic done;
		logic near;
	} near_res_t;

endpackage

/* rtl/prgs_ram.sv */
// Generic single-port-write, registered-read RAM.
// No dependencies.
module prgs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/prgs_near.sv */
// Iterative closeness test: one axis difference per step, one shared 16x16 squarer.
// Depends on prgs_pkg.
module prgs_near #(
	parameter int COORD_BITS = prgs_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [COORD_BITS-1:0]  pt_a [3],
	input  logic signed [COORD_BITS-1:0]  pt_b [3],
	input  logic [prgs_pkg::GAP_W-1:0]    gap,
	output prgs_pkg::near_res_t           res
);
	import prgs_pkg::*;

	localparam int DW = COORD_BITS + 1;
	localparam int CW = (DW > GAP_W) ? DW : GAP_W;
	localparam logic [1:0] LAST_AXIS = 2'd2;

	typedef enum logic [1:0] {N_IDLE, N_DIFF, N_MUL, N_SQ} nstate_t;

	nstate_t          state_q;
	logic [1:0]       axis_q;
	logic [GAP_W-1:0] mag_q;
	logic [ACC_W-1:0] acc_q;

	logic signed [DW-1:0] diff;
	logic [DW-1:0]        mag;
	logic                 far;
	logic [GAP_W-1:0]     mul_op;
	logic [SQ_W-1:0]      prod;

	always_comb begin
		diff   = DW'(pt_a[axis_q]) - DW'(pt_b[axis_q]);
		mag    = diff[DW-1] ? $unsigned(-diff) : $unsigned(diff);
		far    = CW'(mag) >= CW'(gap);
		mul_op = (state_q == N_SQ) ? gap : mag_q;
		prod   = SQ_W'(mul_op) * SQ_W'(mul_op);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			axis_q  <= '0;
			mag_q   <= '0;
			acc_q   <= '0;
			res     <= '0;
		end else begin
			res.done <= 1'b0;
			unique case (state_q)
				N_IDLE: begin
					if (start) begin
						axis_q  <= '0;
						acc_q   <= '0;
						state_q <= N_DIFF;
					end
				end
				N_DIFF: begin
					if (far) begin
						res.done <= 1'b1;
						res.near <= 1'b0;
						state_q  <= N_IDLE;
					end else begin
						mag_q   <= GAP_W'(mag);
						state_q <= N_MUL;
					end
				end
				N_MUL: begin
					acc_q <= acc_q + ACC_W'(prod);
					if (axis_q == LAST_AXIS) begin
						state_q <= N_SQ;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= N_DIFF;
					end
				end
				N_SQ: begin
					res.done <= 1'b1;
					res.near <= acc_q < ACC_W'(prod);
					state_q  <= N_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/point_run_gap_segment_filter_core.sv */
// Point run gap segment filter, top level. Depends on prgs_pkg, prgs_near, prgs_ram.
// Steps: the first point of a run is stored at once; any other point first waits in S_NEAR for the
// per-axis difference/square steps of prgs_near (a far axis ends the test early).
// Closing a kept run reads each emitted point from RAM, then outputs it, and waits on any
// out_ready stall; a final point adds a flush step. One item at a time, in_ready low meanwhile.
// Reset: registers to defaults, run empty; run store is not cleared.
module point_run_gap_segment_filter_core #(
	parameter int RUN_DEPTH  = prgs_pkg::RUN_DEPTH_DEF,
	parameter int COORD_BITS = prgs_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [COORD_BITS-1:0]       pos_x,
	input  logic signed [COORD_BITS-1:0]       pos_y,
	input  logic signed [COORD_BITS-1:0]       pos_z,
	input  logic                               final_point,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [COORD_BITS-1:0]       out_x,
	output logic signed [COORD_BITS-1:0]       out_y,
	output logic signed [COORD_BITS-1:0]       out_z,
	output logic                               run_end,
	input  logic                               wr_en,
	input  logic [prgs_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [prgs_pkg::CFG_DATA_W-1:0]    wr_data
);
	import prgs_pkg::*;
`include "assert_macros.svh"

	localparam int IDX_W = $clog2(RUN_DEPTH);
	localparam int LEN_W = $clog2(RUN_DEPTH + 1);
	localparam int CMP_W = (LEN_W > MINP_W) ? LEN_W : MINP_W;
	localparam int PT_W  = 3 * COORD_BITS;

	typedef enum logic [2:0] {S_IDLE, S_NEAR, S_STORE, S_FLUSH, S_RD, S_OUT} state_t;

	state_t                        state_q;
	logic [GAP_W-1:0]              gap_q;
	logic [MINP_W-1:0]             minp_q;
	logic [LEN_W-1:0]              len_q;
	logic [IDX_W-1:0]              idx_q;
	logic                          end_q;
	logic                          flush_q;
	logic                          last_q;
	logic                          start_q;
	logic signed [COORD_BITS-1:0]  pt_q   [3];
	logic signed [COORD_BITS-1:0]  prev_q [3];

	near_res_t                     near_res;
	logic                          keep;
	logic [PT_W-1:0]               rdata;

	assign keep      = CMP_W'(len_q) >= CMP_W'(minp_q);
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_x     = $signed(rdata[COORD_BITS-1:0]);
	assign out_y     = $signed(rdata[2*COORD_BITS-1:COORD_BITS]);
	assign out_z     = $signed(rdata[PT_W-1:2*COORD_BITS]);
	assign run_end   = end_q;

	prgs_near #(
		.COORD_BITS (COORD_BITS)
	) u_near (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.pt_a   (pt_q),
		.pt_b   (prev_q),
		.gap    (gap_q),
		.res    (near_res)
	);

	prgs_ram #(
		.WIDTH (PT_W),
		.DEPTH (RUN_DEPTH)
	) u_run_store (
		.clk   (clk),
		.we    (state_q == S_STORE),
		.waddr (IDX_W'(len_q)),
		.wdata ({pt_q[2], pt_q[1], pt_q[0]}),
		.re    (state_q == S_RD),
		.raddr (idx_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q  <= GAP_RESET;
			minp_q <= MINP_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_GAP_LIMIT:  gap_q  <= wr_data[GAP_W-1:0];
				REG_MIN_POINTS: minp_q <= wr_data[MINP_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
			idx_q   <= '0;
			end_q   <= 1'b0;
			flush_q <= 1'b0;
			last_q  <= 1'b0;
			start_q <= 1'b0;
			pt_q    <= '{default: '0};
			prev_q  <= '{default: '0};
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						pt_q[0] <= pos_x;
						pt_q[1] <= pos_y;
						pt_q[2] <= pos_z;
						last_q  <= final_point;
						if (len_q != '0) begin
							start_q <= 1'b1;
							state_q <= S_NEAR;
						end else begin
							state_q <= S_STORE;
						end
					end
				end
				S_NEAR: begin
					if (near_res.done) begin
						if (!near_res.near || len_q == LEN_W'(RUN_DEPTH)) begin
							if (keep) begin
								idx_q   <= '0;
								flush_q <= 1'b0;
								state_q <= S_RD;
							end else begin
								len_q   <= '0;
								state_q <= S_STORE;
							end
						end else begin
							state_q <= S_STORE;
						end
					end
				end
				S_STORE: begin
					prev_q  <= pt_q;
					len_q   <= len_q + LEN_W'(1);
					state_q <= last_q ? S_FLUSH : S_IDLE;
				end
				S_FLUSH: begin
					if (keep) begin
						idx_q   <= '0;
						flush_q <= 1'b1;
						state_q <= S_RD;
					end else begin
						len_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_RD: begin
					end_q   <= (LEN_W'(idx_q) + LEN_W'(1)) == len_q;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						if (end_q) begin
							len_q   <= '0;
							state_q <= flush_q ? S_IDLE : S_STORE;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= S_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_ALWAYS(a_len_bound, clk, arst_n, len_q <= LEN_W'(RUN_DEPTH))
	`ASSERT_IMPLY(a_idx_in_run, clk, arst_n, out_valid, LEN_W'(idx_q) < len_q)
	`ASSERT_NEXT(a_busy_after_item, clk, arst_n, in_valid && in_ready, !in_ready)
	`ASSERT_NEXT(a_run_cleared, clk, arst_n, out_valid && out_ready && run_end, len_q == '0)

endmodule
